FILE: hdl/rwm_pkg.sv
`default_nettype none

package rwm_pkg;

    // request codes
    localparam logic [2:0] REQ_WR_WEIGHT = 3'd0;
    localparam logic [2:0] REQ_WR_BIAS   = 3'd1;
    localparam logic [2:0] REQ_RD_WEIGHT = 3'd2;
    localparam logic [2:0] REQ_RD_BIAS   = 3'd3;
    localparam logic [2:0] REQ_SEED      = 3'd4;
    localparam logic [2:0] REQ_MUTATE    = 3'd5;

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // divisor select for the remainder unit
    localparam logic [1:0] MOD_SEL_TOTAL  = 2'd0;
    localparam logic [1:0] MOD_SEL_WEIGHT = 2'd1;
    localparam logic [1:0] MOD_SEL_BIAS   = 2'd2;

    // delta moduli and floor(2^32 / d) reciprocals
    localparam logic [9:0]  WEIGHT_MODULUS = 10'd17;
    localparam logic [9:0]  BIAS_MODULUS   = 10'd513;
    localparam logic [31:0] WEIGHT_RECIP   = 32'd252645135;
    localparam logic [31:0] BIAS_RECIP     = 32'd8372255;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [9:0]         entry_index;
        logic signed [31:0] entry_value;
        logic [31:0]        seed_value;
        logic [12:0]        burst_len;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               status;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hdl/rwm_store.sv
`default_nettype none

module rwm_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // single port, read data registered and held until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/rwm_mod.sv
`default_nettype none

// Remainder of a 32-bit value by one of three fixed divisors.
// Reciprocal multiply, back-multiply, one correction: three stages.
module rwm_mod
    import rwm_pkg::*;
#(
    parameter int TOTAL = 1088,
    localparam int DIV_W = ($clog2(TOTAL + 1) > 10) ? $clog2(TOTAL + 1) : 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_num,
    input  wire logic [1:0]       i_sel,
    output logic                  o_valid,
    output logic      [DIV_W-1:0] o_rem
);

    localparam logic [31:0]      TotalRecip = 32'(64'h1_0000_0000 / TOTAL);
    localparam logic [DIV_W-1:0] TotalDiv   = DIV_W'(TOTAL);

    logic [31:0]      recip;
    logic [DIV_W-1:0] divisor;
    logic [63:0]      prod;

    logic [2:0]       r_vld;
    logic [31:0]      r_q1;
    logic [31:0]      r_num1;
    logic [DIV_W-1:0] r_d1;
    logic [DIV_W:0]   r_rem2;
    logic [DIV_W-1:0] r_d2;
    logic [DIV_W-1:0] r_rem3;

    always_comb begin
        case (i_sel)
            MOD_SEL_WEIGHT: begin
                recip   = WEIGHT_RECIP;
                divisor = DIV_W'(WEIGHT_MODULUS);
            end
            MOD_SEL_BIAS: begin
                recip   = BIAS_RECIP;
                divisor = DIV_W'(BIAS_MODULUS);
            end
            default: begin
                recip   = TotalRecip;
                divisor = TotalDiv;
            end
        endcase
    end

    assign prod = 64'(i_num) * 64'(recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    // quotient estimate is low by at most one, so the remainder is below 2*d
    always_ff @(posedge i_clk) begin
        r_q1   <= prod[63:32];
        r_num1 <= i_num;
        r_d1   <= divisor;
        r_rem2 <= r_num1[DIV_W:0] - (DIV_W+1)'(r_q1[DIV_W:0] * {1'b0, r_d1});
        r_d2   <= r_d1;
        r_rem3 <= (r_rem2 >= {1'b0, r_d2}) ? DIV_W'(r_rem2 - {1'b0, r_d2})
                                           : r_rem2[DIV_W-1:0];
    end

    assign o_valid = r_vld[2];
    assign o_rem   = r_rem3;

endmodule

`default_nettype wire

FILE: hdl/random_weight_mutation_engine.sv
`default_nettype none

// Channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+----------------------------
// in       | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
// out      | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (bias_limit)
//
// One request at a time. A read passes S_REQ, S_RDWAIT and S_RESP, a write S_REQ
// and S_RESP. A mutate burst repeats S_DRAW, S_WAITP, S_WAITD and S_SUM per step,
// plus S_SAT for a bias step; each step uses the three-stage remainder unit twice
// (index, then delta) and the single-port store read-modify-write.
// Reset (synchronous, active low) clears control, the generator (0x74726169) and
// bias_limit (65536); the stores are not cleared. A stalled result sits in the
// output register while the next request is already accepted.

module random_weight_mutation_engine
    import rwm_pkg::*;
#(
    parameter int WEIGHT_DEPTH = 1024,
    parameter int BIAS_DEPTH   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [30:0] i_cfg_data
);

    localparam int TotalCount = WEIGHT_DEPTH + BIAS_DEPTH;
    localparam int WA    = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int BA    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int DIV_W = ($clog2(TotalCount + 1) > 10) ? $clog2(TotalCount + 1) : 10;

    localparam logic [31:0] WeightCnt32 = 32'(WEIGHT_DEPTH);
    localparam logic [31:0] BiasCnt32   = 32'(BIAS_DEPTH);
    localparam logic [31:0] RngReset    = 32'h7472_6169;
    localparam logic [12:0] MaxBurst    = 13'd4096;
    localparam logic [30:0] LimReset    = 31'd65536;
    localparam logic [10:0] WeightOfs   = 11'd8;
    localparam logic [10:0] BiasOfs     = 11'd256;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_REQ    = 9'b000000010,
        S_RDWAIT = 9'b000000100,
        S_DRAW   = 9'b000001000,
        S_WAITP  = 9'b000010000,
        S_WAITD  = 9'b000100000,
        S_SUM    = 9'b001000000,
        S_SAT    = 9'b010000000,
        S_RESP   = 9'b100000000
    } t_state;

    function automatic logic [31:0] xs_next(input logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return (x == 32'd0) ? RngReset : x;
    endfunction

    // control
    t_state       r_state, n_state;
    logic [31:0]  r_rng, n_rng;
    logic [30:0]  r_lim;
    logic [31:0]  r_lim_neg;
    logic         r_out_valid;
    // datapath
    t_in_item     r_req;
    logic [12:0]  r_cnt, n_cnt;
    logic         r_is_bias, n_is_bias;
    logic [WA-1:0] r_waddr, n_waddr;
    logic [BA-1:0] r_baddr, n_baddr;
    logic signed [10:0] r_delta, n_delta;
    logic signed [33:0] r_bsum, n_bsum;
    logic signed [31:0] r_res_value, n_res_value;
    logic         r_res_status, n_res_status;
    t_out_item    r_out;

    // store ports
    logic         w_en, w_we;
    logic [WA-1:0] w_addr;
    logic [7:0]   w_wdata, w_rdata;
    logic         b_en, b_we;
    logic [BA-1:0] b_addr;
    logic [31:0]  b_wdata, b_rdata;

    // remainder unit
    logic         mod_start, mod_valid;
    logic [31:0]  mod_num;
    logic [1:0]   mod_sel;
    logic [DIV_W-1:0] mod_rem;

    logic         in_acc, out_load;
    logic [31:0]  idx32, p32, bidx32, draw_a;
    logic         w_ok, b_ok, p_bias;
    logic [10:0]  rem11, ofs;
    logic signed [11:0] wsum;
    logic signed [33:0] lim34, nlim34;

    rwm_store #(.WIDTH(8), .DEPTH(WEIGHT_DEPTH)) u_weights (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    rwm_store #(.WIDTH(32), .DEPTH(BIAS_DEPTH)) u_biases (
        .i_clk   (i_clk),
        .i_en    (b_en),
        .i_we    (b_we),
        .i_addr  (b_addr),
        .i_wdata (b_wdata),
        .o_rdata (b_rdata)
    );

    rwm_mod #(.TOTAL(TotalCount)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num   (mod_num),
        .i_sel   (mod_sel),
        .o_valid (mod_valid),
        .o_rem   (mod_rem)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // request checks
    assign idx32 = 32'(r_req.entry_index);
    assign w_ok  = idx32 < WeightCnt32;
    assign b_ok  = idx32 < BiasCnt32;

    // drawn parameter index: weights first, then biases
    assign p32    = 32'(mod_rem);
    assign p_bias = p32 >= WeightCnt32;
    assign bidx32 = p32 - WeightCnt32;

    // delta remainder is below 513, fits 11 bits unsigned
    assign rem11  = mod_rem[10:0];
    assign ofs    = r_is_bias ? BiasOfs : WeightOfs;
    assign draw_a = xs_next(r_rng);

    assign wsum   = 12'(signed'(w_rdata)) + 12'(r_delta);
    assign lim34  = signed'({3'b000, r_lim});
    assign nlim34 = 34'(signed'(r_lim_neg));

    assign out_load = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_rng        = r_rng;
        n_cnt        = r_cnt;
        n_is_bias    = r_is_bias;
        n_waddr      = r_waddr;
        n_baddr      = r_baddr;
        n_delta      = r_delta;
        n_bsum       = r_bsum;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        w_en      = 1'b0;
        w_we      = 1'b0;
        w_addr    = r_waddr;
        w_wdata   = r_req.entry_value[7:0];
        b_en      = 1'b0;
        b_we      = 1'b0;
        b_addr    = r_baddr;
        b_wdata   = r_req.entry_value;
        mod_start = 1'b0;
        mod_num   = draw_a;
        mod_sel   = MOD_SEL_TOTAL;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_REQ;
                end
            end

            S_REQ: begin
                n_res_value  = '0;
                n_res_status = STATUS_OK;
                n_state      = S_RESP;
                w_addr       = idx32[WA-1:0];
                b_addr       = idx32[BA-1:0];
                case (r_req.req_type)
                    REQ_WR_WEIGHT: begin
                        if (w_ok) begin
                            w_en = 1'b1;
                            w_we = 1'b1;
                        end else begin
                            n_res_status = STATUS_REJECT;
                        end
                    end
                    REQ_WR_BIAS: begin
                        if (b_ok) begin
                            b_en = 1'b1;
                            b_we = 1'b1;
                        end else begin
                            n_res_status = STATUS_REJECT;
                        end
                    end
                    REQ_RD_WEIGHT: begin
                        if (w_ok) begin
                            w_en      = 1'b1;
                            n_is_bias = 1'b0;
                            n_state   = S_RDWAIT;
                        end else begin
                            n_res_status = STATUS_REJECT;
                        end
                    end
                    REQ_RD_BIAS: begin
                        if (b_ok) begin
                            b_en      = 1'b1;
                            n_is_bias = 1'b1;
                            n_state   = S_RDWAIT;
                        end else begin
                            n_res_status = STATUS_REJECT;
                        end
                    end
                    REQ_SEED: begin
                        n_rng = r_req.seed_value;
                    end
                    REQ_MUTATE: begin
                        if (r_req.burst_len == '0 || r_req.burst_len > MaxBurst) begin
                            n_res_status = STATUS_REJECT;
                        end else begin
                            n_cnt   = r_req.burst_len;
                            n_state = S_DRAW;
                        end
                    end
                    default: begin
                        n_res_status = STATUS_REJECT;
                    end
                endcase
            end

            S_RDWAIT: begin
                n_res_value = r_is_bias ? signed'(b_rdata) : 32'(signed'(w_rdata));
                n_state     = S_RESP;
            end

            // draw 1: parameter index
            S_DRAW: begin
                n_rng     = draw_a;
                mod_start = 1'b1;
                n_state   = S_WAITP;
            end

            // index ready: fetch the entry and start draw 2 for the delta
            S_WAITP: begin
                if (mod_valid) begin
                    n_is_bias = p_bias;
                    n_waddr   = p32[WA-1:0];
                    n_baddr   = bidx32[BA-1:0];
                    w_addr    = p32[WA-1:0];
                    b_addr    = bidx32[BA-1:0];
                    w_en      = !p_bias;
                    b_en      = p_bias;
                    n_rng     = draw_a;
                    mod_start = 1'b1;
                    mod_sel   = p_bias ? MOD_SEL_BIAS : MOD_SEL_WEIGHT;
                    n_state   = S_WAITD;
                end
            end

            // zero delta: one more draw picks the sign of a unit step
            S_WAITD: begin
                if (mod_valid) begin
                    if (rem11 == ofs) begin
                        n_rng   = draw_a;
                        n_delta = draw_a[0] ? 11'sd1 : -11'sd1;
                    end else begin
                        n_delta = signed'(rem11 - ofs);
                    end
                    n_state = S_SUM;
                end
            end

            // a step's write lands well before the next step's read
            S_SUM: begin
                if (r_is_bias) begin
                    n_bsum  = 34'(signed'(b_rdata)) + 34'(r_delta);
                    n_state = S_SAT;
                end else begin
                    w_en = 1'b1;
                    w_we = 1'b1;
                    if (wsum > 12'sd127) begin
                        w_wdata = 8'h7f;
                    end else if (wsum < -12'sd128) begin
                        w_wdata = 8'h80;
                    end else begin
                        w_wdata = wsum[7:0];
                    end
                    n_cnt   = r_cnt - 13'd1;
                    n_state = (r_cnt == 13'd1) ? S_RESP : S_DRAW;
                end
            end

            S_SAT: begin
                b_en = 1'b1;
                b_we = 1'b1;
                if (r_bsum > lim34) begin
                    b_wdata = lim34[31:0];
                end else if (r_bsum < nlim34) begin
                    b_wdata = nlim34[31:0];
                end else begin
                    b_wdata = r_bsum[31:0];
                end
                n_cnt   = r_cnt - 13'd1;
                n_state = (r_cnt == 13'd1) ? S_RESP : S_DRAW;
            end

            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rng       <= RngReset;
            r_lim       <= LimReset;
            r_lim_neg   <= -32'(LimReset);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rng   <= n_rng;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lim     <= i_cfg_data;
                r_lim_neg <= -32'(i_cfg_data);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_item;
        end
        r_cnt        <= n_cnt;
        r_is_bias    <= n_is_bias;
        r_waddr      <= n_waddr;
        r_baddr      <= n_baddr;
        r_delta      <= n_delta;
        r_bsum       <= n_bsum;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out.read_value <= r_res_value;
            r_out.status     <= r_res_status;
        end
    end

endmodule

`default_nettype wire
